@@ design/rcpa_pkg.sv @@
// shared types and constants for the reserved class pool allocator
// no dependencies; used by reserved_class_pool_allocator_core
package rcpa_pkg;

	localparam int DATA_W    = 32;
	localparam int PART_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_FIRST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_LAST  = 3'd4;

	localparam logic KIND_ACQUIRE = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_BAD_SIZE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_PROT,
		ST_CUT,
		ST_DIV,
		ST_MUL,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_LAST_RD,
		ST_LAST_WR,
		ST_BUMP,
		ST_TAKE,
		ST_REL,
		ST_DONE
	} state_t;

endpackage

@@ design/reserved_class_pool_allocator_core.sv @@
// reserved class pool allocator: sequencer, free list memory and shared divider
// depends on rcpa_pkg
//
// channel   direction  handshake              payload
// command   in         start & !busy          kind, importance, wanted_particles,
//                                             particle_bytes, release_offset, release_bytes
// result    out        done (one cycle)       status, granted_particles, block_start,
//                                             block_length, was_reduced, list_overflow,
//                                             shortfall_total, reduced_total, bytes_in_use
// config    in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// one transaction at a time; busy stays high from accept until the done cycle
// release: through the release state to done; zero particle size: straight to done
// acquire: sum of free space, protected reservations, cut, multiply, free list scan and
//   bump of the mark; a cut at the class limit or at the mark runs the 32-step divider;
//   the free list scans use one memory read port
// reset clears the state register and allocator counters at once, no clearing pass
// results cannot be stalled; config is taken only while not busy
module reserved_class_pool_allocator_core #(
	parameter int FREE_SLOTS  = 64,
	parameter int CLASS_COUNT = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic [1:0]                      importance,
	input  logic [rcpa_pkg::PART_W-1:0]     wanted_particles,
	input  logic [rcpa_pkg::PART_W-1:0]     particle_bytes,
	input  logic [rcpa_pkg::DATA_W-1:0]     release_offset,
	input  logic [rcpa_pkg::DATA_W-1:0]     release_bytes,
	output logic                            done,
	output logic                            status,
	output logic [rcpa_pkg::PART_W-1:0]     granted_particles,
	output logic [rcpa_pkg::DATA_W-1:0]     block_start,
	output logic [rcpa_pkg::DATA_W-1:0]     block_length,
	output logic                            was_reduced,
	output logic                            list_overflow,
	output logic [rcpa_pkg::DATA_W-1:0]     shortfall_total,
	output logic [rcpa_pkg::DATA_W-1:0]     reduced_total,
	output logic [rcpa_pkg::DATA_W-1:0]     bytes_in_use,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rcpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcpa_pkg::DATA_W-1:0]     cfg_data
);

	localparam int DW    = rcpa_pkg::DATA_W;
	localparam int PW    = rcpa_pkg::PART_W;
	localparam int IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
	localparam int CNT_W = $clog2(FREE_SLOTS + 1);
	localparam int CLS_W = $clog2(CLASS_COUNT);
	// free bytes plus protected bytes never overflow this width
	localparam int AW    = DW + IDX_W + 2;

	rcpa_pkg::state_t state_q, state_d;

	// configuration
	logic [DW-1:0] pool_q;
	logic [DW-1:0] reserve_q [CLASS_COUNT];

	// allocator state
	logic [DW-1:0]    hw_q;
	logic [DW-1:0]    used_q;
	logic [DW-1:0]    class_used_q [CLASS_COUNT];
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    short_q;
	logic [DW-1:0]    redcnt_q;

	// free list memory
	logic [DW-1:0]    mem_start [FREE_SLOTS];
	logic [DW-1:0]    mem_len   [FREE_SLOTS];
	logic [DW-1:0]    rd_start_q;
	logic [DW-1:0]    rd_len_q;
	logic [IDX_W-1:0] mem_ra;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [DW-1:0]    mem_wstart;
	logic [DW-1:0]    mem_wlen;

	// transaction registers
	logic             kind_q;
	logic [CLS_W-1:0] cls_q;
	logic [PW-1:0]    wanted_q;
	logic [PW-1:0]    pb_q;
	logic [DW-1:0]    roff_q;
	logic [DW-1:0]    rlen_q;
	logic [DW-1:0]    asked_q;
	logic [PW-1:0]    grant_q;
	logic [DW-1:0]    blen_q;
	logic [DW-1:0]    bstart_q;
	logic             status_q;
	logic             reduced_q;
	logic             overflow_q;

	// scan and accumulation
	logic [CNT_W-1:0] idx_q;
	logic             pend_q;
	logic [AW-1:0]    acc_q;
	logic [AW-1:0]    prot_q;
	logic [CLS_W:0]   cc_q;

	// shared restoring divider, one quotient bit per cycle
	logic [DW-1:0]    dvd_q;
	logic [PW-1:0]    rem_q;
	logic [4:0]       dcnt_q;
	logic             second_q;
	logic [PW:0]      div_trial;
	logic             div_ge;
	logic [PW:0]      div_diff;

	logic [CLS_W-1:0] cls_in;
	logic [DW-1:0]    room_above;
	logic [AW-1:0]    avail;
	logic             idx_live;
	logic             scan_fit;

	always_comb begin
		if (32'(importance) >= CLASS_COUNT) begin
			cls_in = CLS_W'(CLASS_COUNT - 1);
		end else begin
			cls_in = CLS_W'(importance);
		end
	end

	assign room_above = (pool_q > hw_q) ? (pool_q - hw_q) : '0;
	assign avail      = (acc_q > prot_q) ? (acc_q - prot_q) : '0;
	assign idx_live   = (idx_q < cnt_q);
	assign scan_fit   = (rd_len_q >= blen_q);
	assign div_trial  = {rem_q, dvd_q[DW-1]};
	assign div_ge     = (div_trial >= {1'b0, pb_q});
	assign div_diff   = div_trial - {1'b0, pb_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rcpa_pkg::ST_IDLE: begin
				if (start) begin
					if (kind == rcpa_pkg::KIND_RELEASE) begin
						state_d = rcpa_pkg::ST_REL;
					end else if (particle_bytes == '0) begin
						state_d = rcpa_pkg::ST_DONE;
					end else begin
						state_d = rcpa_pkg::ST_SUM;
					end
				end
			end
			rcpa_pkg::ST_SUM: begin
				if (!idx_live && !pend_q) state_d = rcpa_pkg::ST_PROT;
			end
			rcpa_pkg::ST_PROT: begin
				if (32'(cc_q) == CLASS_COUNT - 1) state_d = rcpa_pkg::ST_CUT;
			end
			rcpa_pkg::ST_CUT: begin
				if ({{(AW-DW){1'b0}}, asked_q} > avail) begin
					state_d = rcpa_pkg::ST_DIV;
				end else begin
					state_d = rcpa_pkg::ST_MUL;
				end
			end
			rcpa_pkg::ST_DIV: begin
				if (dcnt_q == 5'd31) state_d = rcpa_pkg::ST_MUL;
			end
			rcpa_pkg::ST_MUL: begin
				if (second_q) begin
					state_d = rcpa_pkg::ST_TAKE;
				end else if (grant_q == '0) begin
					state_d = rcpa_pkg::ST_DONE;
				end else begin
					state_d = rcpa_pkg::ST_SCAN_RD;
				end
			end
			rcpa_pkg::ST_SCAN_RD: begin
				state_d = idx_live ? rcpa_pkg::ST_SCAN_CHK : rcpa_pkg::ST_BUMP;
			end
			rcpa_pkg::ST_SCAN_CHK: begin
				if (!scan_fit) begin
					state_d = rcpa_pkg::ST_SCAN_RD;
				end else if (rd_len_q == blen_q) begin
					state_d = rcpa_pkg::ST_LAST_RD;
				end else begin
					state_d = rcpa_pkg::ST_DONE;
				end
			end
			rcpa_pkg::ST_LAST_RD: state_d = rcpa_pkg::ST_LAST_WR;
			rcpa_pkg::ST_LAST_WR: state_d = rcpa_pkg::ST_DONE;
			rcpa_pkg::ST_BUMP: begin
				if ({1'b0, hw_q} + {1'b0, blen_q} > {1'b0, pool_q}) begin
					state_d = rcpa_pkg::ST_DIV;
				end else begin
					state_d = rcpa_pkg::ST_TAKE;
				end
			end
			rcpa_pkg::ST_TAKE: state_d = rcpa_pkg::ST_DONE;
			rcpa_pkg::ST_REL:  state_d = rcpa_pkg::ST_DONE;
			rcpa_pkg::ST_DONE: state_d = rcpa_pkg::ST_IDLE;
			default:           state_d = rcpa_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		busy       = (state_q != rcpa_pkg::ST_IDLE);
		done       = (state_q == rcpa_pkg::ST_DONE);
		cfg_ready  = (state_q == rcpa_pkg::ST_IDLE);
		mem_ra     = idx_q[IDX_W-1:0];
		mem_we     = 1'b0;
		mem_wa     = idx_q[IDX_W-1:0];
		mem_wstart = rd_start_q + blen_q;
		mem_wlen   = rd_len_q - blen_q;
		unique case (state_q)
			rcpa_pkg::ST_LAST_RD: mem_ra = IDX_W'(cnt_q - 1'b1);
			rcpa_pkg::ST_SCAN_CHK: begin
				mem_we = scan_fit && (rd_len_q != blen_q);
			end
			rcpa_pkg::ST_LAST_WR: begin
				mem_we     = 1'b1;
				mem_wstart = rd_start_q;
				mem_wlen   = rd_len_q;
			end
			rcpa_pkg::ST_REL: begin
				mem_we     = (rlen_q != '0) &&
					({1'b0, roff_q} + {1'b0, rlen_q} != {1'b0, hw_q}) &&
					(32'(cnt_q) < FREE_SLOTS);
				mem_wa     = IDX_W'(cnt_q);
				mem_wstart = roff_q;
				mem_wlen   = rlen_q;
			end
			default: ;
		endcase
	end

	// free list memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_start[mem_wa] <= mem_wstart;
			mem_len[mem_wa]   <= mem_wlen;
		end
		rd_start_q <= mem_start[mem_ra];
		rd_len_q   <= mem_len[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rcpa_pkg::ST_IDLE;
			pool_q   <= 32'd65536;
			hw_q     <= '0;
			used_q   <= '0;
			cnt_q    <= '0;
			short_q  <= '0;
			redcnt_q <= '0;
			pend_q   <= 1'b0;
			for (int c = 0; c < CLASS_COUNT; c++) begin
				reserve_q[c]    <= '0;
				class_used_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			// config writes, indexes past the reservations are dropped
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rcpa_pkg::CFG_POOL_SIZE) begin
					pool_q <= cfg_data;
				end else if (cfg_index >= rcpa_pkg::CFG_RES_FIRST &&
					cfg_index <= rcpa_pkg::CFG_RES_LAST &&
					32'(cfg_index - rcpa_pkg::CFG_RES_FIRST) < CLASS_COUNT) begin
					reserve_q[CLS_W'(cfg_index - rcpa_pkg::CFG_RES_FIRST)] <= cfg_data;
				end
			end
			unique case (state_q)
				rcpa_pkg::ST_IDLE: begin
					pend_q <= 1'b0;
				end
				rcpa_pkg::ST_SUM: begin
					pend_q <= idx_live;
				end
				rcpa_pkg::ST_DIV: begin
					if (dcnt_q == 5'd31 && second_q) begin
						short_q  <= short_q + DW'(grant_q - {dvd_q[PW-2:0], div_ge});
						redcnt_q <= redcnt_q + 1'b1;
					end else if (dcnt_q == 5'd31) begin
						short_q  <= short_q + DW'(wanted_q - {dvd_q[PW-2:0], div_ge});
						redcnt_q <= redcnt_q + 1'b1;
					end
				end
				rcpa_pkg::ST_SCAN_CHK: begin
					if (scan_fit) begin
						used_q              <= used_q + blen_q;
						class_used_q[cls_q] <= class_used_q[cls_q] + blen_q;
					end
				end
				rcpa_pkg::ST_LAST_WR: begin
					cnt_q <= cnt_q - 1'b1;
				end
				rcpa_pkg::ST_TAKE: begin
					if (grant_q != '0) begin
						hw_q                <= hw_q + blen_q;
						used_q              <= used_q + blen_q;
						class_used_q[cls_q] <= class_used_q[cls_q] + blen_q;
					end
				end
				rcpa_pkg::ST_REL: begin
					if (rlen_q != '0) begin
						used_q              <= used_q - rlen_q;
						class_used_q[cls_q] <= (class_used_q[cls_q] >= rlen_q) ?
							(class_used_q[cls_q] - rlen_q) : '0;
						if ({1'b0, roff_q} + {1'b0, rlen_q} == {1'b0, hw_q}) begin
							hw_q <= roff_q;
						end else if (32'(cnt_q) < FREE_SLOTS) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload and sequencing registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			rcpa_pkg::ST_IDLE: begin
				kind_q     <= kind;
				cls_q      <= cls_in;
				wanted_q   <= wanted_particles;
				pb_q       <= particle_bytes;
				roff_q     <= release_offset;
				rlen_q     <= release_bytes;
				asked_q    <= DW'(wanted_particles) * DW'(particle_bytes);
				grant_q    <= '0;
				blen_q     <= '0;
				bstart_q   <= '0;
				reduced_q  <= 1'b0;
				overflow_q <= 1'b0;
				second_q   <= 1'b0;
				idx_q      <= '0;
				cc_q       <= '0;
				prot_q     <= '0;
				acc_q      <= '0;
				status_q   <= (kind == rcpa_pkg::KIND_ACQUIRE && particle_bytes == '0) ?
					rcpa_pkg::STATUS_BAD_SIZE : rcpa_pkg::STATUS_OK;
			end
			rcpa_pkg::ST_SUM: begin
				// room above the mark plus every listed free range
				if (idx_q == '0 && !pend_q) begin
					acc_q <= AW'(room_above);
				end else if (pend_q) begin
					acc_q <= acc_q + AW'(rd_len_q);
				end
				if (idx_live) idx_q <= idx_q + 1'b1;
			end
			rcpa_pkg::ST_PROT: begin
				// other classes' unclaimed reservations
				if (CLS_W'(cc_q) != cls_q &&
					class_used_q[CLS_W'(cc_q)] < reserve_q[CLS_W'(cc_q)]) begin
					prot_q <= prot_q + AW'(reserve_q[CLS_W'(cc_q)] -
						class_used_q[CLS_W'(cc_q)]);
				end
				cc_q <= cc_q + 1'b1;
			end
			rcpa_pkg::ST_CUT: begin
				grant_q <= wanted_q;
				dvd_q   <= avail[DW-1:0];
				rem_q   <= '0;
				dcnt_q  <= '0;
				if ({{(AW-DW){1'b0}}, asked_q} > avail) reduced_q <= 1'b1;
			end
			rcpa_pkg::ST_DIV: begin
				dvd_q  <= {dvd_q[DW-2:0], div_ge};
				rem_q  <= div_ge ? div_diff[PW-1:0] : div_trial[PW-1:0];
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 5'd31) grant_q <= {dvd_q[PW-2:0], div_ge};
			end
			rcpa_pkg::ST_MUL: begin
				blen_q <= DW'(grant_q) * DW'(pb_q);
				idx_q  <= '0;
			end
			rcpa_pkg::ST_SCAN_CHK: begin
				if (scan_fit) begin
					bstart_q <= rd_start_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			rcpa_pkg::ST_BUMP: begin
				dvd_q    <= room_above;
				rem_q    <= '0;
				dcnt_q   <= '0;
				second_q <= 1'b1;
				if ({1'b0, hw_q} + {1'b0, blen_q} > {1'b0, pool_q}) reduced_q <= 1'b1;
			end
			rcpa_pkg::ST_TAKE: begin
				bstart_q <= hw_q;
			end
			rcpa_pkg::ST_REL: begin
				overflow_q <= (rlen_q != '0) &&
					({1'b0, roff_q} + {1'b0, rlen_q} != {1'b0, hw_q}) &&
					(32'(cnt_q) >= FREE_SLOTS);
			end
			default: ;
		endcase
	end

	// result ports, valid in the done cycle
	assign status            = status_q;
	assign granted_particles = (kind_q == rcpa_pkg::KIND_ACQUIRE) ? grant_q : '0;
	assign block_start       = (grant_q == '0) ? '0 : bstart_q;
	assign block_length      = (grant_q == '0) ? '0 : blen_q;
	assign was_reduced       = reduced_q;
	assign list_overflow     = overflow_q;
	assign shortfall_total   = short_q;
	assign reduced_total     = redcnt_q;
	assign bytes_in_use      = used_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done outside a transaction");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted command not taken");
	a_bad_size: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> granted_particles == '0 && block_length == '0)
		else $error("grant on bad size");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= FREE_SLOTS) else $error("free count past capacity");

endmodule
